// ===== rtl/sdd_pkg.sv =====
package sdd_pkg;

  // default sizes of the two dense stores
  localparam int unsigned RowCountDefault = 1024;
  localparam int unsigned RankMaxDefault  = 64;

  // field widths
  localparam int unsigned ActionWidth   = 2;
  localparam int unsigned IndexWidth    = 10;
  localparam int unsigned ElemWidth     = 6;
  localparam int unsigned DenseWidth    = 32;
  localparam int unsigned AccWidth      = 64;
  localparam int unsigned RankWidth     = 7;
  localparam int unsigned CfgIndexWidth = 1;
  localparam int unsigned CfgDataWidth  = 7;
  localparam int unsigned RankCmpWidth  = 11;

  // register indexes of the configuration port
  localparam logic [CfgIndexWidth-1:0] CFG_RANK      = 1'b0;
  localparam logic [CfgIndexWidth-1:0] CFG_TRANSPOSE = 1'b1;

  localparam logic [RankWidth-1:0] RankReset = 7'd64;

  // item actions
  typedef enum logic [ActionWidth-1:0] {
    ACT_LOAD_FIRST  = 2'd0,
    ACT_LOAD_SECOND = 2'd1,
    ACT_SAMPLE      = 2'd2
  } action_e;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_BASE,
    ST_WRITE,
    ST_MAC,
    ST_FINISH
  } ctrl_state_e;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic reduce_step;
    logic base_calc;
    logic write_en;
    logic issue;
    logic finish;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_load;
    logic is_sample;
    logic reduce_last;
    logic rank_zero;
    logic issue_last;
    logic pipe_busy;
    logic out_free;
  } dp_status_t;

  // number of compare-subtract steps that fold a row index into the row count
  function automatic int red_steps(input int count);
    int steps;
    steps = 0;
    for (int i = 0; i <= int'(IndexWidth); i++) begin
      if ((longint'(count) << i) < (longint'(1) << IndexWidth)) begin
        steps = i + 1;
      end
    end
    return steps;
  endfunction

  // signed add that clamps at the 64-bit limits
  function automatic logic signed [AccWidth-1:0] sat_add(
    input logic signed [AccWidth-1:0] a,
    input logic signed [AccWidth-1:0] b
  );
    logic signed [AccWidth-1:0] s;
    s = a + b;
    if (a[AccWidth-1] == b[AccWidth-1] && s[AccWidth-1] != a[AccWidth-1]) begin
      s = a[AccWidth-1] ? {1'b1, {(AccWidth-1){1'b0}}} : {1'b0, {(AccWidth-1){1'b1}}};
    end
    return s;
  endfunction

endpackage

// ===== rtl/sdd_if.sv =====
// input item channel
interface sdd_in_if import sdd_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic [ActionWidth-1:0]       action;
  logic [IndexWidth-1:0]        row_index;
  logic [IndexWidth-1:0]        col_index;
  logic [ElemWidth-1:0]         elem_index;
  logic signed [DenseWidth-1:0] dense_value;
  logic signed [AccWidth-1:0]   old_value;
  logic                         last_coord;

  modport source (
    output valid, action, row_index, col_index, elem_index, dense_value, old_value,
           last_coord,
    input  ready
  );
  modport sink (
    input  valid, action, row_index, col_index, elem_index, dense_value, old_value,
           last_coord,
    output ready
  );
endinterface

// result channel
interface sdd_out_if import sdd_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [AccWidth-1:0] new_value;
  logic [IndexWidth-1:0]      out_row;
  logic [IndexWidth-1:0]      out_col;
  logic                       out_last;

  modport source (
    output valid, new_value, out_row, out_col, out_last,
    input  ready
  );
  modport sink (
    input  valid, new_value, out_row, out_col, out_last,
    output ready
  );
endinterface

// configuration write channel
interface sdd_cfg_if import sdd_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CfgIndexWidth-1:0] index;
  logic [CfgDataWidth-1:0]  data;

  modport source (
    output valid, index, data,
    input  ready
  );
  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

// ===== rtl/sdd_ram.sv =====
module sdd_ram #(
  parameter  int unsigned Width     = 32,
  parameter  int unsigned Depth     = 1024,
  localparam int unsigned AddrWidth = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AddrWidth-1:0] waddr_i,
  input  logic [Width-1:0]     wdata_i,
  input  logic                 re_i,
  input  logic [AddrWidth-1:0] raddr_i,
  output logic [Width-1:0]     rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/sdd_ctrl.sv =====
module sdd_ctrl import sdd_pkg::*; #(
  parameter int unsigned ROW_COUNT = RowCountDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  localparam int RedSteps = red_steps(int'(ROW_COUNT));

  ctrl_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (RedSteps > 0) ? ST_REDUCE : ST_BASE;
        end
      end
      ST_REDUCE: begin
        if (status_i.reduce_last) begin
          state_d = ST_BASE;
        end
      end
      ST_BASE: begin
        if (status_i.is_load) begin
          state_d = ST_WRITE;
        end else if (status_i.is_sample) begin
          state_d = status_i.rank_zero ? ST_FINISH : ST_MAC;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_WRITE: begin
        state_d = ST_IDLE;
      end
      ST_MAC: begin
        if (status_i.issue_last) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!status_i.pipe_busy && status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // commands
  always_comb begin
    in_ready_o        = (state_q == ST_IDLE);
    cmd_o             = '0;
    cmd_o.capture     = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.reduce_step = (state_q == ST_REDUCE);
    cmd_o.base_calc   = (state_q == ST_BASE);
    cmd_o.write_en    = (state_q == ST_WRITE);
    cmd_o.issue       = (state_q == ST_MAC);
    cmd_o.finish      = (state_q == ST_FINISH) && !status_i.pipe_busy && status_i.out_free;
  end

endmodule

// ===== rtl/sdd_datapath.sv =====
module sdd_datapath import sdd_pkg::*; #(
  parameter int unsigned ROW_COUNT = RowCountDefault,
  parameter int unsigned RANK_MAX  = RankMaxDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ctrl_cmd_t                    cmd_i,
  output dp_status_t                   status_o,
  // input item fields
  input  logic [ActionWidth-1:0]       action_i,
  input  logic [IndexWidth-1:0]        row_index_i,
  input  logic [IndexWidth-1:0]        col_index_i,
  input  logic [ElemWidth-1:0]         elem_index_i,
  input  logic signed [DenseWidth-1:0] dense_value_i,
  input  logic signed [AccWidth-1:0]   old_value_i,
  input  logic                         last_coord_i,
  // configuration writes
  input  logic                         cfg_valid_i,
  input  logic [CfgIndexWidth-1:0]     cfg_index_i,
  input  logic [CfgDataWidth-1:0]      cfg_data_i,
  // result
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [AccWidth-1:0]   new_value_o,
  output logic [IndexWidth-1:0]        out_row_o,
  output logic [IndexWidth-1:0]        out_col_o,
  output logic                         out_last_o
);

  localparam int unsigned Depth     = ROW_COUNT * RANK_MAX;
  localparam int unsigned AddrWidth = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned ProdWidth = IndexWidth + RankCmpWidth;
  localparam int unsigned EffMax    = (RANK_MAX < 127) ? RANK_MAX : 127;
  localparam int unsigned CntWidth  = $clog2(EffMax + 1);
  localparam int          RedSteps  = red_steps(int'(ROW_COUNT));
  localparam int unsigned ReduceTop = (RedSteps > 0) ? (ROW_COUNT << (RedSteps - 1)) : 0;

  // captured item
  logic [ActionWidth-1:0]       action_q;
  logic [IndexWidth-1:0]        row_q, col_q;
  logic [IndexWidth-1:0]        red_row_q, red_row_d, red_col_q, red_col_d;
  logic [IndexWidth-1:0]        sub_q, sub_d;
  logic [ElemWidth-1:0]         elem_q;
  logic signed [DenseWidth-1:0] dense_q;
  logic signed [AccWidth-1:0]   old_q;
  logic                         last_q;

  // addressing and multiply-accumulate
  logic [AddrWidth-1:0]         row_base_q, col_base_q;
  logic [CntWidth-1:0]          k_q, n_w;
  logic                         rd_v_q, prod_v_q;
  logic signed [AccWidth-1:0]   prod_q, acc_q;
  logic                         elem_ok;
  logic [AddrWidth-1:0]         waddr, row_addr, col_addr, raddr_first, raddr_second;
  logic [DenseWidth-1:0]        rdata_first, rdata_second;

  // configuration and result
  logic [RankWidth-1:0]         rank_q;
  logic                         transpose_q;
  logic                         out_valid_q;
  logic signed [AccWidth-1:0]   new_value_q;
  logic [IndexWidth-1:0]        out_row_q, out_col_q;
  logic                         out_last_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rank_q      <= RankReset;
      transpose_q <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_RANK:      rank_q      <= cfg_data_i[RankWidth-1:0];
        CFG_TRANSPOSE: transpose_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // effective rank, clamped to the row length
  always_comb begin
    if ({{(RankCmpWidth-RankWidth){1'b0}}, rank_q} > RankCmpWidth'(RANK_MAX)) begin
      n_w = CntWidth'(RANK_MAX);
    end else begin
      n_w = CntWidth'(rank_q);
    end
  end

  // row folding: one compare-subtract per step
  always_comb begin
    red_row_d = red_row_q;
    red_col_d = red_col_q;
    sub_d     = sub_q;
    if (cmd_i.capture) begin
      red_row_d = row_index_i;
      red_col_d = col_index_i;
      sub_d     = IndexWidth'(ReduceTop);
    end else if (cmd_i.reduce_step) begin
      if (red_row_q >= sub_q) red_row_d = red_row_q - sub_q;
      if (red_col_q >= sub_q) red_col_d = red_col_q - sub_q;
      sub_d = sub_q >> 1;
    end
  end

  // item capture, folding and base addresses
  always_ff @(posedge clk_i) begin
    red_row_q <= red_row_d;
    red_col_q <= red_col_d;
    sub_q     <= sub_d;
    if (cmd_i.capture) begin
      action_q <= action_i;
      row_q    <= row_index_i;
      col_q    <= col_index_i;
      elem_q   <= elem_index_i;
      dense_q  <= dense_value_i;
      old_q    <= old_value_i;
      last_q   <= last_coord_i;
    end
    if (cmd_i.base_calc) begin
      row_base_q <= AddrWidth'(ProdWidth'(red_row_q) * ProdWidth'(RANK_MAX));
      col_base_q <= AddrWidth'(ProdWidth'(red_col_q) * ProdWidth'(RANK_MAX));
    end
  end

  // store addresses
  assign elem_ok      = {{(RankCmpWidth-ElemWidth){1'b0}}, elem_q} < RankCmpWidth'(RANK_MAX);
  assign waddr        = row_base_q + AddrWidth'(elem_q);
  assign row_addr     = row_base_q + AddrWidth'(k_q);
  assign col_addr     = col_base_q + AddrWidth'(k_q);
  assign raddr_first  = transpose_q ? col_addr : row_addr;
  assign raddr_second = transpose_q ? row_addr : col_addr;

  sdd_ram #(
    .Width (DenseWidth),
    .Depth (Depth)
  ) u_first_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.write_en && elem_ok && action_q == ACT_LOAD_FIRST),
    .waddr_i (waddr),
    .wdata_i (dense_q),
    .re_i    (cmd_i.issue),
    .raddr_i (raddr_first),
    .rdata_o (rdata_first)
  );

  sdd_ram #(
    .Width (DenseWidth),
    .Depth (Depth)
  ) u_second_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.write_en && elem_ok && action_q == ACT_LOAD_SECOND),
    .waddr_i (waddr),
    .wdata_i (dense_q),
    .re_i    (cmd_i.issue),
    .raddr_i (raddr_second),
    .rdata_o (rdata_second)
  );

  // pipeline valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_v_q   <= 1'b0;
      prod_v_q <= 1'b0;
    end else begin
      rd_v_q   <= cmd_i.issue;
      prod_v_q <= rd_v_q;
    end
  end

  // element counter, product register and saturating accumulator
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      k_q <= '0;
    end else if (cmd_i.issue) begin
      k_q <= k_q + CntWidth'(1);
    end
    if (rd_v_q) begin
      prod_q <= AccWidth'($signed(rdata_first) * $signed(rdata_second));
    end
    if (cmd_i.capture) begin
      acc_q <= '0;
    end else if (prod_v_q) begin
      acc_q <= sat_add(acc_q, prod_q);
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      new_value_q <= sat_add(old_q, acc_q);
      out_row_q   <= row_q;
      out_col_q   <= col_q;
      out_last_q  <= last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign new_value_o = new_value_q;
  assign out_row_o   = out_row_q;
  assign out_col_o   = out_col_q;
  assign out_last_o  = out_last_q;

  // status for the controller
  always_comb begin
    status_o             = '0;
    status_o.is_load     = (action_q == ACT_LOAD_FIRST) || (action_q == ACT_LOAD_SECOND);
    status_o.is_sample   = (action_q == ACT_SAMPLE);
    status_o.reduce_last = (sub_q == IndexWidth'(ROW_COUNT));
    status_o.rank_zero   = (n_w == '0);
    status_o.issue_last  = (k_q == n_w - CntWidth'(1));
    status_o.pipe_busy   = rd_v_q || prod_v_q;
    status_o.out_free    = !out_valid_q || out_ready_i;
  end

endmodule

// ===== rtl/sampled_dense_dot_product_unit.sv =====
// channel   dir  payload                                                   transfer
// cfg_chan  in   index, data                                               valid & ready
// in_chan   in   action, row_index, col_index, elem_index, dense_value,    valid & ready
//                old_value, last_coord
// out_chan  out  new_value, out_row, out_col, out_last                     valid & ready
//
// a sample runs through base, multiply-accumulate and finish back to idle, on the single
// multiply-accumulate unit fed one element a cycle by the two store reads; a load runs
// through base and write, a rank zero sample skips multiply-accumulate, an unused action
// is dropped after base; when ROW_COUNT is below 1024, every item adds one folding step per
// halving of the index range (compare-subtract on the row and column indexes)
// the stores have no reset; the result register holds one finished result, so the next
// item is taken while it waits; configuration writes are taken in every cycle
module sampled_dense_dot_product_unit import sdd_pkg::*; #(
  parameter int unsigned ROW_COUNT = RowCountDefault,
  parameter int unsigned RANK_MAX  = RankMaxDefault
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  sdd_cfg_if.sink  cfg_chan,
  sdd_in_if.sink   in_chan,
  sdd_out_if.source out_chan
);

  ctrl_cmd_t  cmd;
  dp_status_t status;
  logic       in_ready;

  assign cfg_chan.ready = 1'b1;
  assign in_chan.ready  = in_ready;

  // sequencer
  sdd_ctrl #(
    .ROW_COUNT (ROW_COUNT)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_chan.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // stores, multiply-accumulate and result register
  sdd_datapath #(
    .ROW_COUNT (ROW_COUNT),
    .RANK_MAX  (RANK_MAX)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .action_i      (in_chan.action),
    .row_index_i   (in_chan.row_index),
    .col_index_i   (in_chan.col_index),
    .elem_index_i  (in_chan.elem_index),
    .dense_value_i (in_chan.dense_value),
    .old_value_i   (in_chan.old_value),
    .last_coord_i  (in_chan.last_coord),
    .cfg_valid_i   (cfg_chan.valid),
    .cfg_index_i   (cfg_chan.index),
    .cfg_data_i    (cfg_chan.data),
    .out_valid_o   (out_chan.valid),
    .out_ready_i   (out_chan.ready),
    .new_value_o   (out_chan.new_value),
    .out_row_o     (out_chan.out_row),
    .out_col_o     (out_chan.out_col),
    .out_last_o    (out_chan.out_last)
  );

endmodule

// ===== rtl/sdd_checker.sv =====
module sdd_protocol_checker import sdd_pkg::*; (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic signed [AccWidth-1:0] new_value_i,
  input logic [IndexWidth-1:0]      out_row_i,
  input logic [IndexWidth-1:0]      out_col_i,
  input logic                       out_last_i
);

  // a stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(new_value_i) && $stable(out_row_i)
                                    && $stable(out_col_i) && $stable(out_last_i))
    else $error("result payload changed while stalled");

  // the unit works on one item at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("second item taken while one is in work");

  // a result never appears right after an input transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> !$past(in_valid_i && in_ready_i))
    else $error("result raised without any work cycles");

endmodule

bind sampled_dense_dot_product_unit sdd_protocol_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_chan.valid),
  .in_ready_i  (in_chan.ready),
  .out_valid_i (out_chan.valid),
  .out_ready_i (out_chan.ready),
  .new_value_i (out_chan.new_value),
  .out_row_i   (out_chan.out_row),
  .out_col_i   (out_chan.out_col),
  .out_last_i  (out_chan.out_last)
);

// ===== dv/sdd_checker.sv =====
`timescale 1ns / 1ps

// passive checker: mirrors the dense stores and registers, predicts every sample
// result and compares it with what comes out of the result channel
module sdd_checker import sdd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  sdd_cfg_if   cfg_chan,
  sdd_in_if    in_chan,
  sdd_out_if   out_chan,
  output int   fail_count_o,
  output int   pending_o
);

  localparam int unsigned StoreDepth = RowCountDefault * RankMaxDefault;

  typedef struct packed {
    logic signed [AccWidth-1:0] value;
    logic [IndexWidth-1:0]      row;
    logic [IndexWidth-1:0]      col;
    logic                       last;
  } sample_result_t;

  logic [DenseWidth-1:0] first_entries  [StoreDepth];
  logic [DenseWidth-1:0] second_entries [StoreDepth];
  logic [RankWidth-1:0]  rank_q;
  logic                  transpose_q;
  sample_result_t        sample_results_q [$];

  // add with clamping, worked out one bit wider than the accumulator
  function automatic logic signed [AccWidth-1:0] clamp_sum(
    input logic signed [AccWidth-1:0] x,
    input logic signed [AccWidth-1:0] y
  );
    logic signed [AccWidth:0] wide;
    wide = {x[AccWidth-1], x} + {y[AccWidth-1], y};
    if (wide[AccWidth] != wide[AccWidth-1]) begin
      return wide[AccWidth] ? {1'b1, {(AccWidth-1){1'b0}}} : {1'b0, {(AccWidth-1){1'b1}}};
    end
    return wide[AccWidth-1:0];
  endfunction

  // old value plus the dot product of the row-side and column-side rows
  function automatic sample_result_t predict_sample(
    input logic [IndexWidth-1:0]      row,
    input logic [IndexWidth-1:0]      col,
    input logic signed [AccWidth-1:0] old,
    input logic                       last
  );
    sample_result_t             res;
    logic signed [AccWidth-1:0] dot;
    logic signed [AccWidth-1:0] lhs;
    logic signed [AccWidth-1:0] rhs;
    logic [DenseWidth-1:0]      row_entry;
    logic [DenseWidth-1:0]      col_entry;
    int                         n;
    int                         row_base;
    int                         col_base;
    n = (rank_q > RankMaxDefault) ? RankMaxDefault : int'(rank_q);
    row_base = (int'(row) % RowCountDefault) * RankMaxDefault;
    col_base = (int'(col) % RowCountDefault) * RankMaxDefault;
    dot = '0;
    for (int k = 0; k < n; k++) begin
      row_entry = transpose_q ? second_entries[row_base + k] : first_entries[row_base + k];
      col_entry = transpose_q ? first_entries[col_base + k] : second_entries[col_base + k];
      lhs = {{(AccWidth-DenseWidth){row_entry[DenseWidth-1]}}, row_entry};
      rhs = {{(AccWidth-DenseWidth){col_entry[DenseWidth-1]}}, col_entry};
      dot = clamp_sum(dot, lhs * rhs);
    end
    res.value = clamp_sum(old, dot);
    res.row   = row;
    res.col   = col;
    res.last  = last;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch_transfers
    sample_result_t want;
    int             addr;
    if (!rst_ni) begin
      rank_q       = RankReset;
      transpose_q  = 1'b0;
      sample_results_q.delete();
      pending_o    = 0;
      fail_count_o = 0;
    end else begin
      // register writes
      if (cfg_chan.valid && cfg_chan.ready) begin
        if (cfg_chan.index == CFG_RANK) begin
          rank_q = cfg_chan.data[RankWidth-1:0];
        end else if (cfg_chan.index == CFG_TRANSPOSE) begin
          transpose_q = cfg_chan.data[0];
        end
      end

      // result transfer against the oldest prediction
      if (out_chan.valid && out_chan.ready) begin
        if (sample_results_q.size() == 0) begin
          $display("%0t: result with none pending, row %0d col %0d value %h", $time,
                   out_chan.out_row, out_chan.out_col, out_chan.new_value);
          fail_count_o++;
        end else begin
          want = sample_results_q.pop_front();
          if (out_chan.new_value !== want.value) begin
            $display("%0t: new_value expected %h actual %h", $time, want.value,
                     out_chan.new_value);
            fail_count_o++;
          end
          if (out_chan.out_row !== want.row) begin
            $display("%0t: out_row expected %0d actual %0d", $time, want.row, out_chan.out_row);
            fail_count_o++;
          end
          if (out_chan.out_col !== want.col) begin
            $display("%0t: out_col expected %0d actual %0d", $time, want.col, out_chan.out_col);
            fail_count_o++;
          end
          if (out_chan.out_last !== want.last) begin
            $display("%0t: out_last expected %0b actual %0b", $time, want.last,
                     out_chan.out_last);
            fail_count_o++;
          end
        end
      end

      // item transfer: loads update the mirror, samples queue a prediction
      if (in_chan.valid && in_chan.ready) begin
        addr = (int'(in_chan.row_index) % RowCountDefault) * RankMaxDefault
               + int'(in_chan.elem_index);
        case (in_chan.action)
          ACT_LOAD_FIRST: begin
            if (in_chan.elem_index < RankMaxDefault) first_entries[addr] = in_chan.dense_value;
          end
          ACT_LOAD_SECOND: begin
            if (in_chan.elem_index < RankMaxDefault) second_entries[addr] = in_chan.dense_value;
          end
          ACT_SAMPLE: begin
            sample_results_q.push_back(predict_sample(in_chan.row_index, in_chan.col_index,
                                                      in_chan.old_value, in_chan.last_coord));
          end
          default: ;
        endcase
      end

      pending_o = sample_results_q.size();
    end
  end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import sdd_pkg::*;

  localparam logic [ActionWidth-1:0] ActUnused    = 2'd3;
  localparam int                     ItemTarget   = 550;
  localparam int                     SettleCycles = 80;
  localparam int                     HoldCycles   = 400;
  localparam int                     PoolSize     = 8;
  localparam logic [DenseWidth-1:0]  DenseMin     = 32'h8000_0000;
  localparam logic [DenseWidth-1:0]  DenseMax     = 32'h7fff_ffff;
  localparam logic [AccWidth-1:0]    AccMin       = 64'h8000_0000_0000_0000;
  localparam logic [AccWidth-1:0]    AccMax       = 64'h7fff_ffff_ffff_ffff;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;

  // which dense entries hold a value, per store and row
  logic [RankMaxDefault-1:0] loaded_mask [2][RowCountDefault];
  logic [IndexWidth-1:0]     row_pool [PoolSize];
  int                        items_sent;
  int                        cur_rank;
  logic                      cur_transpose;
  bit                        sender_eager = 1'b0;
  bit                        hold_req = 1'b0;
  bit                        rx_eager = 1'b0;
  int                        stall_left = 0;

  sdd_cfg_if cfg_chan ();
  sdd_in_if  in_chan ();
  sdd_out_if out_chan ();

  sampled_dense_dot_product_unit dut (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .cfg_chan (cfg_chan),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  sdd_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_chan     (cfg_chan),
    .in_chan      (in_chan),
    .out_chan     (out_chan),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  // mostly short gaps, a few long ones
  function automatic int idle_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [DenseWidth-1:0] rand_dense();
    case ($urandom_range(0, 5))
      0: return DenseMin;
      1: return DenseMax;
      2: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [AccWidth-1:0] rand_old();
    logic [31:0] low;
    low = $urandom();
    case ($urandom_range(0, 5))
      0: return AccMin;
      1: return AccMax;
      2: return {{32{low[31]}}, low};
      default: return {$urandom(), low};
    endcase
  endfunction

  // true when elements 0..n-1 of a row have been written
  function automatic bit prefix_full(input int s, input logic [IndexWidth-1:0] r, input int n);
    for (int k = 0; k < n && k < RankMaxDefault; k++) begin
      if (!loaded_mask[s][r][k]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // row from the pool, preferring rows whose prefix is already loaded; for rank zero, half the time any row
  function automatic logic [IndexWidth-1:0] pick_row(input int s, input int n);
    logic [IndexWidth-1:0] full_rows [$];
    if (n == 0 && $urandom_range(0, 1)) begin
      return IndexWidth'($urandom_range(0, RowCountDefault - 1));
    end
    foreach (row_pool[i]) begin
      if (prefix_full(s, row_pool[i], n)) full_rows.push_back(row_pool[i]);
    end
    if (full_rows.size() > 0 && $urandom_range(0, 3) != 0) begin
      return full_rows[$urandom_range(0, full_rows.size() - 1)];
    end
    return row_pool[$urandom_range(0, PoolSize - 1)];
  endfunction

  // one item on the input channel; leaves valid high for a following item
  task automatic send_item(
    input logic [ActionWidth-1:0] act,
    input logic [IndexWidth-1:0]  row,
    input logic [IndexWidth-1:0]  col,
    input logic [ElemWidth-1:0]   elem,
    input logic [DenseWidth-1:0]  dval,
    input logic [AccWidth-1:0]    oldv,
    input logic                   last
  );
    int gap;
    gap = sender_eager ? 0 : idle_gap();
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_chan.valid       <= 1'b1;
    in_chan.action      <= act;
    in_chan.row_index   <= row;
    in_chan.col_index   <= col;
    in_chan.elem_index  <= elem;
    in_chan.dense_value <= dval;
    in_chan.old_value   <= oldv;
    in_chan.last_coord  <= last;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    @(negedge clk);
    if (act == ACT_LOAD_FIRST || act == ACT_LOAD_SECOND) begin
      loaded_mask[act == ACT_LOAD_SECOND][row][elem] = 1'b1;
      items_sent++;
    end else if (act == ACT_SAMPLE) begin
      items_sent++;
    end
  endtask

  task automatic load_entry(input int s, input logic [IndexWidth-1:0] row,
                            input logic [ElemWidth-1:0] elem);
    send_item(s ? ACT_LOAD_SECOND : ACT_LOAD_FIRST, row,
              IndexWidth'($urandom_range(0, RowCountDefault - 1)),
              elem, rand_dense(), rand_old(), 1'($urandom_range(0, 1)));
  endtask

  // write the missing entries of a row prefix, starting at a random element
  task automatic fill_prefix(input int s, input logic [IndexWidth-1:0] row, input int n);
    int start;
    int k;
    start = $urandom_range(0, RankMaxDefault - 1);
    for (int j = 0; j < n; j++) begin
      k = (start + j) % n;
      if (!loaded_mask[s][row][k]) load_entry(s, row, ElemWidth'(k));
    end
  endtask

  // drop valid and wait for the block to drain
  task automatic settle();
    in_chan.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CfgIndexWidth-1:0] idx,
                           input logic [CfgDataWidth-1:0] data);
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= idx;
    cfg_chan.data  <= data;
    @(posedge clk);
    while (!cfg_chan.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic configure(input int rank_val, input logic trans_val);
    if ($urandom_range(0, 1)) begin
      write_reg(CFG_RANK, CfgDataWidth'(rank_val));
      write_reg(CFG_TRANSPOSE, {{(CfgDataWidth-1){1'b0}}, trans_val});
    end else begin
      write_reg(CFG_TRANSPOSE, {{(CfgDataWidth-1){1'b0}}, trans_val});
      write_reg(CFG_RANK, CfgDataWidth'(rank_val));
    end
    cfg_chan.valid <= 1'b0;
    cur_rank      = rank_val;
    cur_transpose = trans_val;
  endtask

  // load the rows one coordinate needs, then a few samples with extra traffic between
  task automatic run_sequence();
    logic [IndexWidth-1:0] r;
    logic [IndexWidth-1:0] c;
    int                    n;
    int                    rs;
    n  = (cur_rank > RankMaxDefault) ? RankMaxDefault : cur_rank;
    rs = cur_transpose;
    r  = pick_row(rs, n);
    c  = pick_row(1 - rs, n);
    fill_prefix(rs, r, n);
    fill_prefix(1 - rs, c, n);
    repeat ($urandom_range(1, 6)) begin
      case ($urandom_range(0, 9))
        0: send_item(ActUnused, IndexWidth'($urandom()), IndexWidth'($urandom()),
                     ElemWidth'($urandom()), $urandom(), rand_old(),
                     1'($urandom_range(0, 1)));
        1: load_entry($urandom_range(0, 1), $urandom_range(0, 1) ? r : c,
                      ElemWidth'($urandom_range(0, RankMaxDefault - 1)));
        2: load_entry($urandom_range(0, 1), IndexWidth'($urandom_range(0, RowCountDefault - 1)),
                      ElemWidth'($urandom_range(0, RankMaxDefault - 1)));
        default: ;
      endcase
      send_item(ACT_SAMPLE, r, c, ElemWidth'($urandom()), rand_dense(), rand_old(),
                1'($urandom_range(0, 1)));
    end
  endtask

  // result side: random stalls, eager stretches, and one long hold-off on request
  initial begin
    int cycle;
    cycle = 0;
    out_chan.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      cycle++;
      if (cycle % 250 == 0) rx_eager = ($urandom_range(0, 2) == 0);
      if (hold_req) begin
        out_chan.ready <= 1'b0;
        repeat (HoldCycles) @(negedge clk);
        out_chan.ready <= 1'b1;
        hold_req = 1'b0;
      end else if (stall_left > 0) begin
        out_chan.ready <= 1'b0;
        stall_left--;
      end else begin
        out_chan.ready <= 1'b1;
        if (!rx_eager && $urandom_range(0, 3) == 0) stall_left = idle_gap();
      end
    end
  end

  // stimulus and verdict
  initial begin
    int   phase;
    int   rank_pick;
    int   n;
    int   seqs;
    logic trans_pick;
    rst_n               = 1'b0;
    in_chan.valid       = 1'b0;
    in_chan.action      = '0;
    in_chan.row_index   = '0;
    in_chan.col_index   = '0;
    in_chan.elem_index  = '0;
    in_chan.dense_value = '0;
    in_chan.old_value   = '0;
    in_chan.last_coord  = 1'b0;
    cfg_chan.valid      = 1'b0;
    cfg_chan.index      = '0;
    cfg_chan.data       = '0;
    items_sent          = 0;
    foreach (loaded_mask[s, r]) loaded_mask[s][r] = '0;
    row_pool[0] = '0;
    row_pool[1] = '1;
    for (int i = 2; i < PoolSize; i++) begin
      row_pool[i] = IndexWidth'($urandom_range(1, RowCountDefault - 2));
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    configure(2, 1'b0);

    // two most negative products overflow the dot product to the ceiling
    send_item(ACT_LOAD_FIRST, '0, '1, 6'd0, DenseMin, '0, 1'b1);
    send_item(ACT_LOAD_FIRST, '0, '1, 6'd1, DenseMin, '1, 1'b0);
    send_item(ACT_LOAD_SECOND, '1, '0, 6'd0, DenseMin, AccMax, 1'b0);
    send_item(ACT_LOAD_SECOND, '1, '0, 6'd1, DenseMin, AccMin, 1'b1);
    send_item(ACT_SAMPLE, '0, '1, '0, '0, '0, 1'b0);
    send_item(ACT_SAMPLE, '0, '1, '1, '1, AccMin, 1'b1);
    // mixed signs push the most negative old value below the floor
    send_item(ACT_LOAD_SECOND, '1, '0, 6'd0, DenseMax, '0, 1'b0);
    send_item(ACT_LOAD_SECOND, '1, '0, 6'd1, DenseMax, '0, 1'b0);
    send_item(ACT_SAMPLE, '0, '1, '0, '0, AccMin, 1'b0);
    // positive products lift the most positive old value past the ceiling
    send_item(ACT_LOAD_FIRST, '0, '1, 6'd0, DenseMax, '0, 1'b1);
    send_item(ACT_LOAD_FIRST, '0, '1, 6'd1, DenseMax, '0, 1'b0);
    send_item(ACT_SAMPLE, '0, '1, '0, '0, AccMax, 1'b1);
    // unused action code is dropped
    send_item(ActUnused, '1, '1, '1, '1, '1, 1'b1);
    // highest element position
    send_item(ACT_LOAD_FIRST, '1, '0, '1, 32'h1234_5678, '0, 1'b0);
    send_item(ACT_LOAD_SECOND, '0, '1, '1, 32'hedcb_a988, '0, 1'b0);
    // row and column at the opposite ends
    send_item(ACT_LOAD_FIRST, '1, '0, 6'd0, 32'h0001_0000, '0, 1'b0);
    send_item(ACT_LOAD_FIRST, '1, '0, 6'd1, 32'hffff_0000, '0, 1'b0);
    send_item(ACT_LOAD_SECOND, '0, '1, 6'd0, '1, '0, 1'b0);
    send_item(ACT_LOAD_SECOND, '0, '1, 6'd1, 32'h0003_8000, '0, 1'b0);
    send_item(ACT_SAMPLE, '1, '0, '0, '0, 64'd1, 1'b1);

    // random phases, each under its own register setting
    phase = 0;
    while (items_sent < ItemTarget) begin
      settle();
      case (phase)
        0: rank_pick = 1;
        1: rank_pick = 0;
        2: rank_pick = RankMaxDefault;
        3: rank_pick = 127;
        default: begin
          case ($urandom_range(0, 9))
            0: rank_pick = 0;
            1: rank_pick = $urandom_range(33, 127);
            default: rank_pick = $urandom_range(1, 16);
          endcase
        end
      endcase
      trans_pick = 1'((phase < 4) ? (phase % 2) : $urandom_range(0, 1));
      configure(rank_pick, trans_pick);
      n = (rank_pick > RankMaxDefault) ? RankMaxDefault : rank_pick;
      seqs = (n >= 32) ? $urandom_range(1, 2) : $urandom_range(3, 8);
      // long receiver hold-off while items keep coming back to back
      if (phase == 0) begin
        hold_req     = 1'b1;
        sender_eager = 1'b1;
        seqs         = 12;
      end else begin
        sender_eager = ($urandom_range(0, 3) == 0);
      end
      repeat (seqs) run_sequence();
      phase++;
    end

    settle();
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/sdd_pkg.sv
rtl/sdd_if.sv
rtl/sdd_ram.sv
rtl/sdd_ctrl.sv
rtl/sdd_datapath.sv
rtl/sampled_dense_dot_product_unit.sv
rtl/sdd_checker.sv
dv/sdd_checker.sv
dv/tb.sv
